// ===== rtl/ara_pkg.sv =====
// ----------------------------------------------------------------------------
// ara_pkg
// Shared widths, constants, codes and types of the ADC running averager.
// ----------------------------------------------------------------------------
package ara_pkg;

    // field and state widths
    localparam int OPCODE_W = 2;
    localparam int CONV_W   = 12;
    localparam int LEVEL_W  = 20;
    localparam int SUM_W    = 28;
    localparam int COUNT_W  = 8;
    localparam int VPC_W    = 24;
    localparam int VOLTS_W  = 28;

    // fraction bits dropped from level times volts_per_code
    localparam int VOLTS_SHIFT = 16;

    // sample level is held with 8 fraction bits
    localparam int LEVEL_FRAC = 8;

    // count at which sum and count are halved
    localparam logic [COUNT_W-1:0] HALVE_AT = 8'd254;

    // reset value of the scale register, about 3.3 / 4095 volt per code
    localparam logic [VPC_W-1:0] VPC_RESET = 24'd13520;

    // default number of conversions per sample
    localparam int CONV_PER_SAMPLE_DEF = 4;

    // request codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE      = 2'd0,
        OP_READ_AVG    = 2'd1,
        OP_READ_LATEST = 2'd2,
        OP_CLEAR       = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    // start request to the shared divider
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== rtl/ara_divider.sv =====
// ----------------------------------------------------------------------------
// ara_divider
// Restoring divider, one quotient bit per cycle, shared by the sample mean
// and the read-average path. Done is high for one cycle together with the
// final quotient.
// ----------------------------------------------------------------------------
module ara_divider
    import ara_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic [SUM_W-1:0] quotient,
    output logic             done
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               fits;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // iteration control
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/ara_scaler.sv =====
// ----------------------------------------------------------------------------
// ara_scaler
// Registered multiply of the result level by the volts-per-code scale,
// keeping the bits above the dropped fraction.
// ----------------------------------------------------------------------------
module ara_scaler
    import ara_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [LEVEL_W-1:0] level,
    input  logic [VPC_W-1:0]   scale,
    output logic [VOLTS_W-1:0] volts
);

    logic [LEVEL_W+VPC_W-1:0] product;
    logic [VOLTS_W-1:0]       volts_reg;

    // level times scale, full width
    assign product = {{VPC_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, scale};

    // capture the scaled value
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            volts_reg <= product[VOLTS_SHIFT +: VOLTS_W];
        end
    end

    assign volts = volts_reg;

endmodule

// ===== rtl/adc_running_average_core.sv =====
// ----------------------------------------------------------------------------
// adc_running_average_core
// Sample and read-average with nonzero count run through the 28-step shared
// divider; the other requests skip it. A new request is taken only after the
// previous result has been accepted. Reset clears the sequencer and averager
// state and loads the default scale; the result level and volts are not reset.
// ----------------------------------------------------------------------------
module adc_running_average_core
    import ara_pkg::*;
#(
    parameter int CONVERSIONS_PER_SAMPLE = CONV_PER_SAMPLE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [VPC_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CONV_W-1:0]   conv_a,
    input  logic [CONV_W-1:0]   conv_b,
    input  logic [CONV_W-1:0]   conv_c,
    input  logic [CONV_W-1:0]   conv_d,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEVEL_W-1:0]  level,
    output logic [VOLTS_W-1:0]  volts
);

    // conversions in use, kept within one to four
    localparam int NCONV = (CONVERSIONS_PER_SAMPLE < 1) ? 1 :
                           (CONVERSIONS_PER_SAMPLE > 4) ? 4 : CONVERSIONS_PER_SAMPLE;
    localparam int TOTAL_W = CONV_W + 2;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [VPC_W-1:0]    vpc_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LEVEL_W-1:0]  held_reg, held_next;
    logic [LEVEL_W-1:0]  latest_reg, latest_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;

    logic [TOTAL_W-1:0]  total;
    logic [SUM_W-1:0]    sum_plus;
    logic [COUNT_W-1:0]  count_plus;
    logic [LEVEL_W-1:0]  div_level;
    logic [SUM_W-1:0]    div_quotient;
    logic                div_done;
    div_req_t            div_req;
    logic                mul_load;

    // sum of the conversions in use
    always_comb
    begin
        total = TOTAL_W'(conv_a);
        if (NCONV >= 2)
        begin
            total = total + TOTAL_W'(conv_b);
        end
        if (NCONV >= 3)
        begin
            total = total + TOTAL_W'(conv_c);
        end
        if (NCONV >= 4)
        begin
            total = total + TOTAL_W'(conv_d);
        end
    end

    // running sum update with the new quotient
    assign div_level  = div_quotient[LEVEL_W-1:0];
    assign sum_plus   = sum_reg + SUM_W'(div_level);
    assign count_plus = count_reg + 1'b1;

    // sequencer: next state, state updates and divider requests
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        held_next        = held_reg;
        latest_next      = latest_reg;
        level_next       = level_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mul_load         = 1'b0;
        in_ready         = 1'b0;
        out_valid        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next = op_t'(opcode);
                    case (op_t'(opcode))
                        OP_SAMPLE:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = SUM_W'({total, {LEVEL_FRAC{1'b0}}});
                            div_req.divisor  = COUNT_W'(NCONV);
                            state_next       = ST_DIV;
                        end
                        OP_READ_AVG:
                        begin
                            if (count_reg != '0)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = sum_reg;
                                div_req.divisor  = count_reg;
                                state_next       = ST_DIV;
                            end
                            else
                            begin
                                level_next = held_reg;
                                state_next = ST_MUL;
                            end
                        end
                        OP_READ_LATEST:
                        begin
                            level_next = latest_reg;
                            state_next = ST_MUL;
                        end
                        OP_CLEAR:
                        begin
                            sum_next    = '0;
                            count_next  = '0;
                            held_next   = '0;
                            latest_next = '0;
                            level_next  = '0;
                            state_next  = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    level_next = div_level;
                    state_next = ST_MUL;
                    if (op_reg == OP_SAMPLE)
                    begin
                        latest_next = div_level;
                        if (count_plus == HALVE_AT)
                        begin
                            sum_next   = sum_plus >> 1;
                            count_next = count_plus >> 1;
                        end
                        else
                        begin
                            sum_next   = sum_plus;
                            count_next = count_plus;
                        end
                    end
                    else
                    begin
                        held_next  = div_level;
                        sum_next   = '0;
                        count_next = '0;
                    end
                end
            end
            ST_MUL:
            begin
                mul_load   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register and averager state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_SAMPLE;
            sum_reg    <= '0;
            count_reg  <= '0;
            held_reg   <= '0;
            latest_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            held_reg   <= held_next;
            latest_reg <= latest_next;
        end
    end

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpc_reg <= VPC_RESET;
        end
        else if (cfg_wr_en)
        begin
            vpc_reg <= cfg_wr_data;
        end
    end

    // result level
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    // shared divider
    ara_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // voltage scaling
    ara_scaler u_scaler
    (
        .clk   (clk),
        .load  (mul_load),
        .level (level_reg),
        .scale (vpc_reg),
        .volts (volts)
    );

    assign level = level_reg;

`ifndef SYNTHESIS
    // never ready while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n) div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide state");

    // sample count is halved before it can rest at the limit
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != HALVE_AT)
        else $error("sample count reached the halving limit");

    // a result follows the scaling cycle
    assert property (@(posedge clk) disable iff (!rst_n) mul_load |=> out_valid)
        else $error("no result after scaling");
`endif

endmodule
